@@ rtl/core/bps_pkg.sv @@
// bps_pkg: shared types, constants and pattern tables for the beep pattern sequencer.
// Depends on nothing; used by bps_step and beep_pattern_sequencer.

package bps_pkg;

  // Pattern ids that need their own sequencing
  localparam logic [3:0] ID_NONE     = 4'd0;
  localparam logic [3:0] ID_CRIT_LOW = 4'd1;
  localparam logic [3:0] ID_DEAD     = 4'd10;

  // Tone codes
  localparam logic [2:0] TONE_315  = 3'd0;
  localparam logic [2:0] TONE_440  = 3'd1;
  localparam logic [2:0] TONE_1250 = 3'd2;
  localparam logic [2:0] TONE_1400 = 3'd3;
  localparam logic [2:0] TONE_1760 = 3'd4;
  localparam logic [2:0] TONE_OFF  = 3'd7;

  // Critical-low pattern limits
  localparam logic [6:0] CRIT_HIGH_END  = 7'd50;
  localparam logic [6:0] CRIT_LOW_END   = 7'd100;
  localparam logic [6:0] CRIT_BURSTS    = 7'd3;
  localparam logic [6:0] CRIT_PAUSE_END = 7'd100;

  // Dead pattern limits
  localparam logic [6:0] DEAD_BURST_END = 7'd100;
  localparam logic [6:0] DEAD_BURSTS    = 7'd4;

  // Configuration register indexes
  localparam logic CFG_REPEAT_ENABLE  = 1'b0;
  localparam logic CFG_PATTERN_ENABLE = 1'b1;

  localparam logic [14:0] PATTERN_ENABLE_RESET = 15'h7FFF;

  localparam int unsigned NUM_WINDOWS = 5;

  // Window table: count of windows, inclusive phase limit and tone of each window.
  // Ids none, critical low and dead are sequenced separately and have no windows.
  localparam logic [2:0] PAT_LEN [16] = '{
    3'd0, 3'd0, 3'd5, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1,
    3'd3, 3'd5, 3'd0, 3'd1, 3'd1, 3'd4, 3'd5, 3'd5
  };

  localparam logic [6:0] PAT_LIM [16][NUM_WINDOWS] = '{
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd26, 7'd39, 7'd64, 7'd77},
    '{7'd13, 7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd25, 7'd50, 7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd26, 7'd0,  7'd0,  7'd0},
    '{7'd25, 7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd26, 7'd39, 7'd0,  7'd0},
    '{7'd13, 7'd26, 7'd39, 7'd52, 7'd65},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd13, 7'd26, 7'd39, 7'd52, 7'd0},
    '{7'd13, 7'd26, 7'd39, 7'd52, 7'd65},
    '{7'd13, 7'd26, 7'd39, 7'd52, 7'd65}
  };

  localparam logic [2:0] PAT_TONE [16][NUM_WINDOWS] = '{
    '{TONE_315,  TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_315,  TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_1250, TONE_OFF, TONE_1250, TONE_OFF, TONE_1250},
    '{TONE_1250, TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_1250, TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_1250, TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_1760, TONE_1400, TONE_315, TONE_315, TONE_315},
    '{TONE_1250, TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_1760, TONE_OFF, TONE_1760, TONE_315, TONE_315},
    '{TONE_1760, TONE_OFF, TONE_1760, TONE_OFF, TONE_1760},
    '{TONE_315,  TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_440,  TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_315,  TONE_315, TONE_315,  TONE_315, TONE_315},
    '{TONE_315,  TONE_OFF, TONE_315,  TONE_OFF, TONE_315},
    '{TONE_315,  TONE_OFF, TONE_315,  TONE_OFF, TONE_315},
    '{TONE_1760, TONE_OFF, TONE_1760, TONE_OFF, TONE_1760}
  };

  // Sequencer state
  typedef struct packed {
    logic [3:0] pattern_id;
    logic [6:0] phase_count;
    logic [6:0] burst_count;
    logic [6:0] pause_count;
    logic       second_pass;
    logic       tone_state;
    logic [2:0] tone_select;
    logic       active_flag;
  } state_t;

  // One result transaction
  typedef struct packed {
    logic       tone_on;
    logic [2:0] tone_code;
    logic       beeping;
    logic [3:0] active_id;
  } result_t;

  // Configuration as seen by the step logic
  typedef struct packed {
    logic        repeat_enable;
    logic [14:0] pattern_enable;
  } cfg_t;

endpackage

@@ rtl/core/bps_if.sv @@
// bps_item_if / bps_result_if: valid/ready channels of the beep pattern sequencer.
// Standalone; no package dependency.

interface bps_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] beep_id;

  modport source (output valid, output action, output beep_id, input ready);
  modport sink   (input valid, input action, input beep_id, output ready);
endinterface

interface bps_result_if;
  logic       valid;
  logic       ready;
  logic       tone_on;
  logic [2:0] tone_code;
  logic       beeping;
  logic [3:0] active_id;

  modport source (output valid, output tone_on, output tone_code, output beeping,
                  output active_id, input ready);
  modport sink   (input valid, input tone_on, input tone_code, input beeping,
                  input active_id, output ready);
endinterface

@@ rtl/core/bps_step.sv @@
// bps_step: next-state logic of the beep pattern sequencer for one transaction.
// Depends on bps_pkg (state_t, cfg_t, pattern tables and limits).

module bps_step (
  input  bps_pkg::state_t st,
  input  bps_pkg::cfg_t   cfg,
  input  logic            action,
  input  logic [3:0]      beep_id,
  output bps_pkg::state_t st_next
);

  logic [3:0] gate_idx;
  logic       gated_on;
  logic       found;
  logic [2:0] win_tone;
  logic       win_first;
  logic [2:0] len;

  assign gate_idx = st.pattern_id - 4'd1;
  assign gated_on = (st.pattern_id != bps_pkg::ID_NONE) && cfg.pattern_enable[gate_idx];
  assign len      = bps_pkg::PAT_LEN[st.pattern_id];

  // Find the first window whose limit covers the current phase
  always_comb begin
    found     = 1'b0;
    win_tone  = bps_pkg::TONE_OFF;
    win_first = 1'b0;
    for (int w = 0; w < bps_pkg::NUM_WINDOWS; w++) begin
      if (!found && (3'(w) < len) && (st.phase_count <= bps_pkg::PAT_LIM[st.pattern_id][w]))
      begin
        found     = 1'b1;
        win_tone  = bps_pkg::PAT_TONE[st.pattern_id][w];
        win_first = (w == 0);
      end
    end
  end

  // Advance the running pattern or load a new one
  always_comb begin
    st_next = st;
    if (action) begin
      st_next.pattern_id  = beep_id;
      st_next.phase_count = '0;
      st_next.burst_count = '0;
      st_next.pause_count = '0;
      st_next.second_pass = 1'b0;
    end else if (gated_on) begin
      case (st.pattern_id)
        bps_pkg::ID_CRIT_LOW: begin
          if (st.burst_count < bps_pkg::CRIT_BURSTS) begin
            st_next.tone_state = 1'b1;
            if (st.phase_count <= bps_pkg::CRIT_HIGH_END) begin
              st_next.active_flag = 1'b1;
              st_next.phase_count = st.phase_count + 7'd1;
              st_next.tone_select = bps_pkg::TONE_1250;
            end else if (st.phase_count <= bps_pkg::CRIT_LOW_END) begin
              st_next.phase_count = st.phase_count + 7'd1;
              st_next.tone_select = bps_pkg::TONE_315;
            end else begin
              st_next.phase_count = '0;
              st_next.burst_count = st.burst_count + 7'd1;
            end
          end else if (st.pause_count <= bps_pkg::CRIT_PAUSE_END) begin
            st_next.pause_count = st.pause_count + 7'd1;
            st_next.tone_state  = 1'b0;
          end else if (!st.second_pass) begin
            st_next.burst_count = '0;
            st_next.second_pass = 1'b1;
          end else begin
            st_next.tone_state  = 1'b0;
            st_next.burst_count = '0;
            st_next.pause_count = '0;
            st_next.second_pass = 1'b0;
            if (!cfg.repeat_enable) begin
              st_next.active_flag = 1'b0;
              st_next.pattern_id  = bps_pkg::ID_NONE;
            end
          end
        end
        bps_pkg::ID_DEAD: begin
          if (st.phase_count < bps_pkg::DEAD_BURSTS) begin
            if (st.burst_count <= bps_pkg::DEAD_BURST_END) begin
              st_next.active_flag = 1'b1;
              st_next.tone_state  = 1'b1;
              st_next.tone_select = bps_pkg::TONE_1250;
              st_next.burst_count = st.burst_count + 7'd1;
            end else begin
              st_next.phase_count = st.phase_count + 7'd1;
              st_next.burst_count = '0;
            end
          end else begin
            st_next.phase_count = '0;
            st_next.tone_state  = 1'b0;
            if (!cfg.repeat_enable) begin
              st_next.active_flag = 1'b0;
              st_next.pattern_id  = bps_pkg::ID_NONE;
            end
          end
        end
        default: begin
          if (found) begin
            if (win_first) begin
              st_next.active_flag = 1'b1;
            end
            if (win_tone == bps_pkg::TONE_OFF) begin
              st_next.tone_state = 1'b0;
            end else begin
              st_next.tone_state  = 1'b1;
              st_next.tone_select = win_tone;
            end
            st_next.phase_count = st.phase_count + 7'd1;
          end else begin
            st_next.phase_count = '0;
            st_next.tone_state  = 1'b0;
            if (!cfg.repeat_enable) begin
              st_next.active_flag = 1'b0;
              st_next.pattern_id  = bps_pkg::ID_NONE;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/core/beep_pattern_sequencer.sv @@
// beep_pattern_sequencer: one result transaction per item; an accepted item is held in the
// input register until bps_step consumes it, then its result goes into the result register.
// Throughput: one item per cycle while the result buffer has room (bps_step is combinational);
// a two-entry result buffer keeps item.ready off result.ready (drops only when all are full).
// Reset (rst, synchronous, active high): pattern idle, tone off, counters clear, repeat 0,
// pattern_enable all ones, buffers empty. Uses bps_pkg, bps_if.sv and bps_step.

module beep_pattern_sequencer (
  input  logic                clk,
  input  logic                rst,
  bps_item_if.sink            item,
  bps_result_if.source        result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [14:0]         cfg_data
);

  bps_pkg::cfg_t    cfg;
  bps_pkg::state_t  st;
  bps_pkg::state_t  st_next;
  bps_pkg::result_t push_data;
  bps_pkg::result_t out_data;
  bps_pkg::result_t skid_data;

  logic       in_valid;
  logic       in_action;
  logic [3:0] in_beep_id;
  logic       out_valid;
  logic       skid_valid;
  logic       buf_full;
  logic       advance;
  logic       pop;
  logic       take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable  <= 1'b0;
      cfg.pattern_enable <= bps_pkg::PATTERN_ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::CFG_REPEAT_ENABLE:  cfg.repeat_enable  <= cfg_data[0];
        bps_pkg::CFG_PATTERN_ENABLE: cfg.pattern_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake bookkeeping
  assign buf_full   = out_valid && skid_valid;
  assign advance    = in_valid && !buf_full;
  assign item.ready = !in_valid || !buf_full;
  assign take       = item.valid && item.ready;
  assign pop        = out_valid && result.ready;

  // Input register: hold the transaction until the step logic consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_action  <= item.action;
      in_beep_id <= item.beep_id;
    end
  end

  bps_step u_step (
    .st      (st),
    .cfg     (cfg),
    .action  (in_action),
    .beep_id (in_beep_id),
    .st_next (st_next)
  );

  // Sequencer state: advance once per consumed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign push_data.tone_on   = st_next.tone_state;
  assign push_data.tone_code = st_next.tone_select;
  assign push_data.beeping   = st_next.active_flag;
  assign push_data.active_id = st_next.pattern_id;

  // Result buffer: output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= advance;
        end else begin
          out_valid <= advance;
        end
      end else if (advance) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (advance) begin
          skid_data <= push_data;
        end
      end else if (advance) begin
        out_data <= push_data;
      end
    end else if (advance) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.tone_on   = out_data.tone_on;
  assign result.tone_code = out_data.tone_code;
  assign result.beeping   = out_data.beeping;
  assign result.active_id = out_data.active_id;

`ifndef NO_ASSERTIONS
  // Skid entry is only used behind a valid output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // State moves only when a transaction is consumed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("sequencer state changed without a transaction");

  // Critical-low burst count never passes its burst limit
  a_crit_bursts: assert property (@(posedge clk) disable iff (rst)
    (st.pattern_id == bps_pkg::ID_CRIT_LOW) |-> (st.burst_count <= bps_pkg::CRIT_BURSTS))
    else $error("critical-low burst count out of range");

  // Dead pattern phase never passes its burst limit
  a_dead_phase: assert property (@(posedge clk) disable iff (rst)
    (st.pattern_id == bps_pkg::ID_DEAD) |-> (st.phase_count <= bps_pkg::DEAD_BURSTS))
    else $error("dead pattern phase out of range");
`endif

endmodule
